FILE: rtl/core/ist_pkg.sv
// Shared types and constants for the integer set table.
// No dependencies; used by integer_set_table_core.
`timescale 1ns / 1ps

package ist_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int SIZE_W   = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [2:0] {
		REQ_INSERT = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_EXISTS = 3'd2,
		REQ_FIRST  = 3'd3,
		REQ_NEXT   = 3'd4
	} req_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FETCH,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [2:0]               req_type;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic                     item_valid;
		logic signed [DATA_W-1:0] item_value;
		logic                     rejected;
		logic [SIZE_W-1:0]        set_size;
	} rsp_t;

endpackage

FILE: rtl/core/ist_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ist_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/integer_set_table_core.sv
// Top level of the integer set table: sequencer, counters and result buffer.
// Depends on ist_pkg and ist_ram.
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// req       in   req_valid/req_ready    ist_pkg::req_t (req_type, value)
// rsp       out  rsp_valid/rsp_ready    ist_pkg::rsp_t (found .. set_size)
//
// Sequencing: one item at a time. Entries live in one RAM with a single read
// port, so insert, remove and exists scan one entry per cycle (no scan for an
// empty set). Remove then closes the gap, one entry moved per cycle. First/next
// fetch one entry, or none when no entry comes back; ignored codes go straight
// to the response.
// Reset clears count, iterator and control; the RAM needs no clearing since
// only entries below the count are ever read.
// A result waiting in the output buffer does not block the next item; the
// sequencer only stalls in its final state if the buffer is still full.

module integer_set_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ist_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ist_pkg::rsp_t rsp
);

	localparam int CNT_W = ist_pkg::CNT_W;
	localparam int IDX_W = ist_pkg::IDX_W;
	localparam int DW    = ist_pkg::DATA_W;

	ist_pkg::state_t     state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    iter_q, iter_d;
	logic [CNT_W-1:0]    idx_q, idx_d;       // entry whose read data arrives next
	logic [2:0]          op_q, op_d;
	logic [DW-1:0]       val_q, val_d;
	ist_pkg::rsp_t       res_q, res_d;       // result under construction
	ist_pkg::rsp_t       rsp_d;              // result with the final size
	ist_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;
	logic                load;

	// RAM ports
	logic                mem_we, mem_re;
	logic [IDX_W-1:0]    mem_waddr, mem_raddr;
	logic [DW-1:0]       mem_wdata, mem_rdata;

	logic [CNT_W-1:0]    idx_nxt;
	logic [CNT_W-1:0]    next_pos;
	logic                hit;

	ist_ram #(
		.DEPTH(ist_pkg::CAPACITY),
		.WIDTH(DW),
		.AW(IDX_W)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign req_ready = (state_q == ist_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_nxt  = idx_q + CNT_W'(1);
	assign hit      = (mem_rdata == val_q);
	// next steps forward but never beyond the count
	assign next_pos = (iter_q < count_q) ? (iter_q + CNT_W'(1)) : iter_q;

	always_comb begin
		rsp_d          = res_q;
		rsp_d.set_size = ist_pkg::SIZE_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ist_pkg::ST_IDLE;
			count_q     <= '0;
			iter_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			iter_q  <= iter_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		op_q  <= op_d;
		val_q <= val_d;
		res_q <= res_d;
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		iter_d    = iter_q;
		idx_d     = idx_q;
		op_d      = op_q;
		val_d     = val_q;
		res_d     = res_q;
		load      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = '0;

		unique case (state_q)
			ist_pkg::ST_IDLE: begin
				if (req_valid) begin
					op_d  = req.req_type;
					val_d = req.value;
					res_d = '0;
					idx_d = '0;
					unique case (req.req_type) inside
						ist_pkg::REQ_INSERT, ist_pkg::REQ_REMOVE, ist_pkg::REQ_EXISTS: begin
							if (count_q == '0) begin
								// empty set: nothing to scan
								if (req.req_type == ist_pkg::REQ_INSERT) begin
									mem_we    = 1'b1;
									mem_wdata = req.value;
									count_d   = CNT_W'(1);
								end
								state_d = ist_pkg::ST_RESP;
							end else begin
								mem_re  = 1'b1;
								state_d = ist_pkg::ST_SCAN;
							end
						end
						ist_pkg::REQ_FIRST: begin
							iter_d = '0;
							if (count_q != '0) begin
								mem_re  = 1'b1;
								state_d = ist_pkg::ST_FETCH;
							end else begin
								state_d = ist_pkg::ST_RESP;
							end
						end
						ist_pkg::REQ_NEXT: begin
							iter_d = next_pos;
							if (next_pos < count_q) begin
								mem_re    = 1'b1;
								mem_raddr = next_pos[IDX_W-1:0];
								state_d   = ist_pkg::ST_FETCH;
							end else begin
								state_d = ist_pkg::ST_RESP;
							end
						end
						default: begin
							state_d = ist_pkg::ST_RESP;
						end
					endcase
				end
			end

			ist_pkg::ST_SCAN: begin
				if (hit) begin
					res_d.found = 1'b1;
					if (op_q == ist_pkg::REQ_REMOVE) begin
						if (idx_nxt < count_q) begin
							mem_re    = 1'b1;
							mem_raddr = idx_nxt[IDX_W-1:0];
							idx_d     = idx_nxt;
							state_d   = ist_pkg::ST_SHIFT;
						end else begin
							count_d = count_q - CNT_W'(1);
							state_d = ist_pkg::ST_RESP;
						end
					end else begin
						state_d = ist_pkg::ST_RESP;
					end
				end else if (idx_nxt < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_nxt[IDX_W-1:0];
					idx_d     = idx_nxt;
				end else begin
					// miss over the whole table
					if (op_q == ist_pkg::REQ_INSERT) begin
						if (count_q >= CNT_W'(ist_pkg::CAPACITY)) begin
							res_d.rejected = 1'b1;
						end else begin
							mem_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
					end
					state_d = ist_pkg::ST_RESP;
				end
			end

			ist_pkg::ST_SHIFT: begin
				// entry idx_q moves down one place
				mem_we    = 1'b1;
				mem_waddr = idx_q[IDX_W-1:0] - IDX_W'(1);
				mem_wdata = mem_rdata;
				if (idx_nxt < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_nxt[IDX_W-1:0];
					idx_d     = idx_nxt;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = ist_pkg::ST_RESP;
				end
			end

			ist_pkg::ST_FETCH: begin
				res_d.item_valid = 1'b1;
				res_d.item_value = $signed(mem_rdata);
				state_d          = ist_pkg::ST_RESP;
			end

			ist_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					load    = 1'b1;
					state_d = ist_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = ist_pkg::ST_IDLE;
			end
		endcase
	end

	// count never exceeds the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ist_pkg::CAPACITY))
		else $error("element count above capacity");

	// an accepted item always starts a sequence
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q != ist_pkg::ST_IDLE)
		else $error("accepted item left the sequencer idle");

	// count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
		|| (count_q + CNT_W'(1) == $past(count_q)))
		else $error("element count jumped");

	// a shift never writes below entry zero
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ist_pkg::ST_SHIFT |-> idx_q != '0)
		else $error("shift from entry zero");

	// a result is buffered only from the final state
	a_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> state_q == ist_pkg::ST_RESP && state_d == ist_pkg::ST_IDLE)
		else $error("result loaded outside the final state");

endmodule
